/* hdl/ptsl_pkg.sv */
// ----------------------------------------------------------------------------
// ptsl_pkg
// Shared types and constants for the peer table with sequence and liveness.
// ----------------------------------------------------------------------------
package ptsl_pkg;

   localparam int MAX_PEERS_DEF = 8;
   localparam int MAC_W         = 48;
   localparam int CSR_IDX_W     = 2;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_REMOVE  = 3'd1;
   localparam logic [2:0] OP_ACCEPT  = 3'd2;
   localparam logic [2:0] OP_SEEN    = 3'd3;
   localparam logic [2:0] OP_REFRESH = 3'd4;
   localparam logic [2:0] OP_CLASH   = 3'd5;
   localparam logic [2:0] OP_TICK    = 3'd6;
   // spare request code: changes nothing, answers ok low
   localparam logic [2:0] OP_UNUSED  = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_SELF_ID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_MAC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd2;

   typedef struct packed {
      logic [7:0]       node_id;
      logic [7:0]       role;
      logic [MAC_W-1:0] mac;
      logic [15:0]      last_seq;
      logic             have_seq;
      logic [31:0]      last_seen;
      logic             connected;
   } entry_type;

endpackage

/* hdl/ptsl_ram.sv */
// ----------------------------------------------------------------------------
// ptsl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/peer_table_seq_liveness.sv */
// ----------------------------------------------------------------------------
// peer_table_seq_liveness
// Ordered peer table with lookup by node id or MAC, sequence replay check
// and liveness timeout; entries are held in one RAM.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+----------------------
//  request   | start, busy, req_*                      | beat on start & !busy
//  response  | rsp_valid, rsp_*                        | one-cycle strobe
//  config    | csr_valid, csr_ready, csr_index, csr_wdata | valid & ready
//
// A request, apart from the spare code and a clash check on the own id,
// scans every stored entry with a read, then an evaluate step (set by the
// registered read of the entry RAM), then a decision, a read-modify-write
// where needed and the response. Remove also moves each later entry down.
// Reset empties the table at once through the entry count; no clearing pass.
// The response cannot be stalled; busy holds off requests meanwhile.
// ----------------------------------------------------------------------------
module peer_table_seq_liveness #(
   parameter int MAX_PEERS = ptsl_pkg::MAX_PEERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_type,
   input  logic [7:0]                    req_node_id,
   input  logic [7:0]                    req_role,
   input  logic [ptsl_pkg::MAC_W-1:0]    req_mac,
   input  logic [15:0]                   req_seq,
   input  logic [31:0]                   req_now_ms,
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic [3:0]                    rsp_peer_count,
   output logic [3:0]                    rsp_connected_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ptsl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptsl_pkg::MAC_W-1:0]    csr_wdata
);

   localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CW = $clog2(MAX_PEERS + 1);
   localparam int EW = $bits(ptsl_pkg::entry_type);

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_EV, S_DECIDE, S_FIX_RD, S_FIX_EV, S_MV_RD, S_MV_WR
   } state_type;

   state_type state_ff;

   // configuration
   logic [7:0]                 self_id_ff;
   logic [ptsl_pkg::MAC_W-1:0] self_mac_ff;
   logic [31:0]                timeout_ff;

   // latched request
   logic [2:0]                 op_ff;
   logic [7:0]                 id_ff;
   logic [7:0]                 role_ff;
   logic [ptsl_pkg::MAC_W-1:0] mac_ff;
   logic [15:0]                seq_ff;
   logic [31:0]                now_ff;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] conn_ff;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] k_ff;
   logic [IW-1:0] kid_ff;
   logic [IW-1:0] kmac_ff;
   logic          hid_ff;
   logic          hmac_ff;
   logic          hconn_ff;
   logic          ok_ff;
   logic          rsp_valid_ff;

   // RAM ports
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   ptsl_pkg::entry_type wr_entry;
   logic [IW-1:0]       rd_addr;
   logic [EW-1:0]       rd_raw;
   ptsl_pkg::entry_type rd_entry;

   ptsl_ram #(.WIDTH(EW), .DEPTH(MAX_PEERS), .AW(IW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = ptsl_pkg::entry_type'(rd_raw);

   // evaluate helpers
   logic        id_match, mac_match, expired, last_entry, seq_newer;
   logic [15:0] seq_diff;
   logic [31:0] age;

   assign id_match   = (rd_entry.node_id == id_ff);
   assign mac_match  = (rd_entry.mac == mac_ff);
   assign age        = now_ff - rd_entry.last_seen;
   assign expired    = rd_entry.connected && (age > timeout_ff);
   assign last_entry = (CW'(idx_ff) + CW'(1)) >= count_ff;
   assign seq_diff   = seq_ff - rd_entry.last_seq;
   assign seq_newer  = !rd_entry.have_seq || (seq_diff != 16'd0 && !seq_diff[15]);

   // pick the read address for the state about to evaluate
   always_comb begin
      case (state_ff)
         S_FIX_RD: rd_addr = k_ff;
         S_MV_RD:  rd_addr = idx_ff + IW'(1);
         default:  rd_addr = idx_ff;
      endcase
   end

   // write port: tick clear, append, read-modify-write, compaction
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_entry = rd_entry;
      case (state_ff)
         S_EV: begin
            if (op_ff == ptsl_pkg::OP_TICK && expired) begin
               wr_en              = 1'b1;
               wr_entry.connected = 1'b0;
            end
         end
         S_DECIDE: begin
            wr_addr           = IW'(count_ff);
            wr_entry.node_id  = id_ff;
            wr_entry.role     = role_ff;
            wr_entry.mac      = mac_ff;
            wr_entry.last_seq = 16'd0;
            wr_entry.have_seq = 1'b0;
            wr_entry.last_seen = 32'd0;
            wr_entry.connected = 1'b0;
            wr_en = (op_ff == ptsl_pkg::OP_ADD) && !hid_ff && !hmac_ff &&
                    (count_ff < CW'(MAX_PEERS));
         end
         S_FIX_EV: begin
            wr_addr = k_ff;
            case (op_ff)
               ptsl_pkg::OP_ADD: begin
                  wr_en         = 1'b1;
                  wr_entry.role = role_ff;
                  wr_entry.mac  = mac_ff;
               end
               ptsl_pkg::OP_ACCEPT: begin
                  wr_en              = seq_newer;
                  wr_entry.have_seq  = 1'b1;
                  wr_entry.last_seq  = seq_ff;
                  wr_entry.last_seen = now_ff;
                  wr_entry.connected = 1'b1;
               end
               ptsl_pkg::OP_SEEN: begin
                  wr_en              = 1'b1;
                  wr_entry.last_seen = now_ff;
                  wr_entry.connected = 1'b1;
               end
               ptsl_pkg::OP_REFRESH: begin
                  wr_en              = 1'b1;
                  wr_entry.role      = role_ff;
                  wr_entry.last_seen = now_ff;
                  wr_entry.connected = 1'b1;
               end
               default: wr_en = 1'b0;
            endcase
         end
         S_MV_WR: wr_en = 1'b1;
         default: wr_en = 1'b0;
      endcase
   end

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff  <= 8'd1;
         self_mac_ff <= '0;
         timeout_ff  <= 32'd5000;
      end else if (csr_valid) begin
         case (csr_index)
            ptsl_pkg::CSR_SELF_ID:  self_id_ff  <= csr_wdata[7:0];
            ptsl_pkg::CSR_SELF_MAC: self_mac_ff <= csr_wdata;
            ptsl_pkg::CSR_TIMEOUT:  timeout_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         conn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= req_type;
                  id_ff    <= req_node_id;
                  role_ff  <= req_role;
                  mac_ff   <= req_mac;
                  seq_ff   <= req_seq;
                  now_ff   <= req_now_ms;
                  idx_ff   <= '0;
                  hid_ff   <= 1'b0;
                  hmac_ff  <= 1'b0;
                  hconn_ff <= 1'b0;
                  ok_ff    <= 1'b0;
                  if (req_type == ptsl_pkg::OP_UNUSED) begin
                     rsp_valid_ff <= 1'b1;
                  end else if (req_type == ptsl_pkg::OP_CLASH &&
                               req_node_id == self_id_ff) begin
                     ok_ff        <= (req_mac != self_mac_ff);
                     rsp_valid_ff <= 1'b1;
                  end else if (count_ff == '0) begin
                     state_ff <= S_DECIDE;
                  end else begin
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: state_ff <= S_EV;
            S_EV: begin
               if (op_ff == ptsl_pkg::OP_TICK && expired) begin
                  conn_ff <= conn_ff - CW'(1);
               end
               if (op_ff == ptsl_pkg::OP_CLASH && id_match && !mac_match) begin
                  ok_ff <= 1'b1;
               end
               if (id_match && !hid_ff) begin
                  hid_ff   <= 1'b1;
                  kid_ff   <= idx_ff;
                  hconn_ff <= rd_entry.connected;
               end
               if (mac_match && !hmac_ff) begin
                  hmac_ff <= 1'b1;
                  kmac_ff <= idx_ff;
               end
               if (last_entry) begin
                  state_ff <= S_DECIDE;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_RD;
               end
            end
            S_DECIDE: begin
               state_ff <= S_IDLE;
               case (op_ff)
                  ptsl_pkg::OP_ADD: begin
                     if (hid_ff) begin
                        k_ff     <= kid_ff;
                        state_ff <= S_FIX_RD;
                     end else if (hmac_ff) begin
                        k_ff     <= kmac_ff;
                        state_ff <= S_FIX_RD;
                     end else if (count_ff < CW'(MAX_PEERS)) begin
                        count_ff <= count_ff + CW'(1);
                        ok_ff    <= 1'b1;
                     end
                  end
                  ptsl_pkg::OP_REMOVE: begin
                     if (hid_ff) begin
                        ok_ff   <= 1'b1;
                        conn_ff <= conn_ff - CW'(hconn_ff);
                        idx_ff  <= kid_ff;
                        if ((CW'(kid_ff) + CW'(1)) < count_ff) begin
                           state_ff <= S_MV_RD;
                        end else begin
                           count_ff <= count_ff - CW'(1);
                        end
                     end
                  end
                  ptsl_pkg::OP_ACCEPT, ptsl_pkg::OP_REFRESH: begin
                     if (hmac_ff) begin
                        k_ff     <= kmac_ff;
                        state_ff <= S_FIX_RD;
                     end
                  end
                  ptsl_pkg::OP_SEEN: begin
                     if (hid_ff) begin
                        k_ff     <= kid_ff;
                        state_ff <= S_FIX_RD;
                     end
                  end
                  default: ;
               endcase
               if (state_ff == S_DECIDE) begin
                  // response leaves unless a further step was chosen above
                  rsp_valid_ff <= !((op_ff == ptsl_pkg::OP_ADD && (hid_ff || hmac_ff)) ||
                     (op_ff == ptsl_pkg::OP_REMOVE && hid_ff &&
                      (CW'(kid_ff) + CW'(1)) < count_ff) ||
                     ((op_ff == ptsl_pkg::OP_ACCEPT || op_ff == ptsl_pkg::OP_REFRESH)
                      && hmac_ff) ||
                     (op_ff == ptsl_pkg::OP_SEEN && hid_ff));
               end
            end
            S_FIX_RD: state_ff <= S_FIX_EV;
            S_FIX_EV: begin
               if (wr_en) begin
                  ok_ff <= 1'b1;
                  if (op_ff != ptsl_pkg::OP_ADD && !rd_entry.connected) begin
                     conn_ff <= conn_ff + CW'(1);
                  end
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_MV_RD: state_ff <= S_MV_WR;
            S_MV_WR: begin
               // advance the hole one place up the table
               idx_ff <= idx_ff + IW'(1);
               if ((CW'(idx_ff) + CW'(2)) < count_ff) begin
                  state_ff <= S_MV_RD;
               end else begin
                  count_ff     <= count_ff - CW'(1);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = ok_ff;
   assign rsp_peer_count      = 4'(count_ff);
   assign rsp_connected_count = 4'(conn_ff);

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_PEERS))
      else $error("entry count beyond table depth");

   a_conn_le_count: assert property (@(posedge clock) disable iff (reset)
      conn_ff <= count_ff)
      else $error("connected count exceeds entry count");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the peer table: drives requests with and without gaps,
// predicts each response from its own copy of the table and compares
// ok, peer count and connected count on every response strobe.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = ptsl_pkg::MAX_PEERS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int POOL = 12;

   typedef struct {
      logic       ok;
      logic [3:0] peer_count;
      logic [3:0] connected_count;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_type = '0;
   logic [7:0] req_node_id = '0;
   logic [7:0] req_role = '0;
   logic [ptsl_pkg::MAC_W-1:0] req_mac = '0;
   logic [15:0] req_seq = '0;
   logic [31:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_ok;
   logic [3:0] rsp_peer_count;
   logic [3:0] rsp_connected_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ptsl_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ptsl_pkg::MAC_W-1:0] csr_wdata = '0;

   peer_table_seq_liveness dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_node_id(req_node_id), .req_role(req_role),
      .req_mac(req_mac), .req_seq(req_seq), .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_ok(rsp_ok), .rsp_peer_count(rsp_peer_count),
      .rsp_connected_count(rsp_connected_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow copy of the peer table and of the registers.
   logic [7:0]                 tbl_id      [NSLOT];
   logic [7:0]                 tbl_role    [NSLOT];
   logic [ptsl_pkg::MAC_W-1:0] tbl_mac     [NSLOT];
   logic [15:0]                tbl_seq     [NSLOT];
   logic                       tbl_has_seq [NSLOT];
   logic [31:0]                tbl_seen    [NSLOT];
   logic                       tbl_conn    [NSLOT];
   int                         tbl_used = 0;
   logic [7:0]                 own_id = 8'd1;
   logic [ptsl_pkg::MAC_W-1:0] own_mac = '0;
   logic [31:0]                idle_limit = 32'd5000;

   outcome_type pending_q[$];
   int n_items = 0;
   int n_checked = 0;
   int n_errors = 0;
   int n_cycles = 0;
   bit allow_gaps = 1'b1;

   // Stimulus pools so that lookups hit often.
   logic [7:0]                 id_pool  [POOL];
   logic [ptsl_pkg::MAC_W-1:0] mac_pool [POOL];
   logic [15:0]                seq_base = '0;
   logic [31:0]                clock_ms = '0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog: the slowest legal run is far below this.
   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Check every response beat against the oldest prediction.
   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            $error("response with no request outstanding");
            n_errors++;
         end else begin
            exp_o = pending_q.pop_front();
            n_checked++;
            if (rsp_ok !== exp_o.ok) begin
               $error("ok: expected %0d actual %0d", exp_o.ok, rsp_ok);
               n_errors++;
            end
            if (rsp_peer_count !== exp_o.peer_count) begin
               $error("peer_count: expected %0d actual %0d",
                      exp_o.peer_count, rsp_peer_count);
               n_errors++;
            end
            if (rsp_connected_count !== exp_o.connected_count) begin
               $error("connected_count: expected %0d actual %0d",
                      exp_o.connected_count, rsp_connected_count);
               n_errors++;
            end
         end
      end
   end

   function automatic int lookup_id(logic [7:0] id);
      for (int i = 0; i < tbl_used; i++)
         if (tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int lookup_mac(logic [ptsl_pkg::MAC_W-1:0] m);
      for (int i = 0; i < tbl_used; i++)
         if (tbl_mac[i] == m) return i;
      return -1;
   endfunction

   // Apply one request to the shadow table and queue the expected response.
   task automatic apply_request(logic [2:0] op, logic [7:0] id, logic [7:0] role,
                                logic [ptsl_pkg::MAC_W-1:0] mac, logic [15:0] seq,
                                logic [31:0] now);
      int k;
      int conn;
      logic ok;
      logic [15:0] d;
      outcome_type o;
      ok = 1'b0;
      conn = 0;
      case (op)
         ptsl_pkg::OP_ADD: begin
            k = lookup_id(id);
            if (k < 0) k = lookup_mac(mac);
            if (k >= 0) begin
               tbl_role[k] = role;
               tbl_mac[k] = mac;
               ok = 1'b1;
            end else if (tbl_used < NSLOT) begin
               tbl_id[tbl_used] = id;
               tbl_role[tbl_used] = role;
               tbl_mac[tbl_used] = mac;
               tbl_seq[tbl_used] = '0;
               tbl_has_seq[tbl_used] = 1'b0;
               tbl_seen[tbl_used] = '0;
               tbl_conn[tbl_used] = 1'b0;
               tbl_used++;
               ok = 1'b1;
            end
         end
         ptsl_pkg::OP_REMOVE: begin
            k = lookup_id(id);
            if (k >= 0) begin
               // close the gap, keep insertion order
               for (int i = k; i + 1 < tbl_used; i++) begin
                  tbl_id[i] = tbl_id[i+1];
                  tbl_role[i] = tbl_role[i+1];
                  tbl_mac[i] = tbl_mac[i+1];
                  tbl_seq[i] = tbl_seq[i+1];
                  tbl_has_seq[i] = tbl_has_seq[i+1];
                  tbl_seen[i] = tbl_seen[i+1];
                  tbl_conn[i] = tbl_conn[i+1];
               end
               tbl_used--;
               ok = 1'b1;
            end
         end
         ptsl_pkg::OP_ACCEPT: begin
            k = lookup_mac(mac);
            if (k >= 0) begin
               d = seq - tbl_seq[k];
               if (!tbl_has_seq[k] || (d != 0 && d < 16'h8000)) begin
                  tbl_has_seq[k] = 1'b1;
                  tbl_seq[k] = seq;
                  tbl_seen[k] = now;
                  tbl_conn[k] = 1'b1;
                  ok = 1'b1;
               end
            end
         end
         ptsl_pkg::OP_SEEN: begin
            k = lookup_id(id);
            if (k >= 0) begin
               tbl_seen[k] = now;
               tbl_conn[k] = 1'b1;
               ok = 1'b1;
            end
         end
         ptsl_pkg::OP_REFRESH: begin
            k = lookup_mac(mac);
            if (k >= 0) begin
               tbl_seen[k] = now;
               tbl_conn[k] = 1'b1;
               tbl_role[k] = role;
               ok = 1'b1;
            end
         end
         ptsl_pkg::OP_CLASH: begin
            if (id == own_id) ok = (mac != own_mac);
            else
               for (int i = 0; i < tbl_used; i++)
                  if (tbl_id[i] == id && tbl_mac[i] != mac) ok = 1'b1;
         end
         ptsl_pkg::OP_TICK: begin
            for (int i = 0; i < tbl_used; i++)
               if (tbl_conn[i] && (now - tbl_seen[i]) > idle_limit)
                  tbl_conn[i] = 1'b0;
         end
         default: ;
      endcase
      for (int i = 0; i < tbl_used; i++)
         if (tbl_conn[i]) conn++;
      o.ok = ok;
      o.peer_count = tbl_used[3:0];
      o.connected_count = conn[3:0];
      pending_q.push_back(o);
   endtask

   // Send one request beat; start stays high if the next beat follows at once.
   task automatic send_request(logic [2:0] op, logic [7:0] id, logic [7:0] role,
                               logic [ptsl_pkg::MAC_W-1:0] mac, logic [15:0] seq,
                               logic [31:0] now);
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= op;
      req_node_id <= id;
      req_role <= role;
      req_mac <= mac;
      req_seq <= seq;
      req_now_ms <= now;
      do @(posedge clock); while (busy);
      apply_request(op, id, role, mac, seq, now);
      n_items++;
   endtask

   // Drop start and hold until every response is back.
   task automatic hold_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_q.size() != 0);
   endtask

   task automatic write_csr(logic [ptsl_pkg::CSR_IDX_W-1:0] idx,
                            logic [ptsl_pkg::MAC_W-1:0] val);
      hold_until_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ptsl_pkg::CSR_SELF_ID:  own_id = val[7:0];
         ptsl_pkg::CSR_SELF_MAC: own_mac = val;
         ptsl_pkg::CSR_TIMEOUT:  idle_limit = val[31:0];
         default: ;
      endcase
   endtask

   function automatic logic [ptsl_pkg::MAC_W-1:0] rand_mac();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[ptsl_pkg::MAC_W-1:0];
   endfunction

   // One random request: mostly pooled ids and MACs, sane sequence numbers
   // and advancing time; now and then full-range noise.
   task automatic send_random(bit wide_noise);
      logic [2:0] op;
      int p;
      int q;
      logic [7:0] id;
      logic [ptsl_pkg::MAC_W-1:0] mac;
      logic [15:0] seq;
      p = int'($urandom_range(0, POOL - 1));
      q = ($urandom_range(0, 9) < 8) ? p : int'($urandom_range(0, POOL - 1));
      id = id_pool[p];
      mac = mac_pool[q];
      case ($urandom_range(0, 19))
         0, 1, 2, 3:     op = ptsl_pkg::OP_ADD;
         4, 5:           op = ptsl_pkg::OP_REMOVE;
         6, 7, 8, 9, 10: op = ptsl_pkg::OP_ACCEPT;
         11, 12:         op = ptsl_pkg::OP_SEEN;
         13, 14:         op = ptsl_pkg::OP_REFRESH;
         15, 16:         op = ptsl_pkg::OP_CLASH;
         17, 18:         op = ptsl_pkg::OP_TICK;
         default:        op = ptsl_pkg::OP_UNUSED;
      endcase
      if (op == ptsl_pkg::OP_CLASH && $urandom_range(0, 3) == 0) id = own_id;
      case ($urandom_range(0, 9))
         0:       seq = seq_base;                                // replay
         1:       seq = seq_base - 16'($urandom_range(1, 40));   // older
         2:       seq = 16'($urandom());                         // anywhere
         default: seq = seq_base + 16'($urandom_range(1, 4));
      endcase
      seq_base = seq;
      clock_ms = clock_ms + $urandom_range(0, 150);
      if (wide_noise) begin
         id = 8'($urandom());
         mac = rand_mac();
         clock_ms = $urandom();
      end
      send_request(op, id, 8'($urandom()), mac, seq, clock_ms);
   endtask

   task automatic fill_pools();
      for (int i = 0; i < POOL; i++) begin
         id_pool[i] = 8'($urandom());
         mac_pool[i] = rand_mac();
      end
      // pin the extremes of id and MAC into the pools
      id_pool[0] = 8'h00;
      id_pool[1] = 8'hFF;
      mac_pool[0] = '0;
      mac_pool[1] = {ptsl_pkg::MAC_W{1'b1}};
   endtask

   // Directed corners: full table, updates, replay window, clash, timeout, removal and the spare code.
   task automatic test_directed();
      write_csr(ptsl_pkg::CSR_TIMEOUT, 48'd100);
      for (int i = 0; i < NSLOT; i++)
         send_request(ptsl_pkg::OP_ADD, 8'(i + 10), 8'(i), 48'h100 + 48'(i), '0, '0);
      send_request(ptsl_pkg::OP_ADD, 8'd99, 8'd1, 48'h999, '0, '0);        // table full
      send_request(ptsl_pkg::OP_ADD, 8'd10, 8'hFF, 48'hFFFF_FFFF_FFFF, '0, '0); // by id
      send_request(ptsl_pkg::OP_ADD, 8'd98, 8'h00, 48'h101, '0, '0);       // update by mac
      send_request(ptsl_pkg::OP_ACCEPT, '0, '0, 48'h102, 16'hFFFF, 32'd10); // first seq
      send_request(ptsl_pkg::OP_ACCEPT, '0, '0, 48'h102, 16'hFFFF, 32'd11); // replay
      send_request(ptsl_pkg::OP_ACCEPT, '0, '0, 48'h102, 16'h7FFF, 32'd12); // half way
      send_request(ptsl_pkg::OP_ACCEPT, '0, '0, 48'h102, 16'h7FFE, 32'd13); // newest
      send_request(ptsl_pkg::OP_ACCEPT, '0, '0, 48'h777, 16'h0001, 32'd14); // unknown
      send_request(ptsl_pkg::OP_SEEN, 8'd13, '0, '0, '0, 32'hFFFF_FFF0);
      send_request(ptsl_pkg::OP_REFRESH, '0, 8'h5A, 48'h104, '0, 32'd50);
      send_request(ptsl_pkg::OP_CLASH, 8'd1, '0, 48'h0, '0, '0);     // own id, own mac
      send_request(ptsl_pkg::OP_CLASH, 8'd1, '0, 48'h5, '0, '0);     // own id, other mac
      send_request(ptsl_pkg::OP_CLASH, 8'd12, '0, 48'h102, '0, '0);  // same pair
      send_request(ptsl_pkg::OP_CLASH, 8'd12, '0, 48'h103, '0, '0);  // other mac
      send_request(ptsl_pkg::OP_TICK, '0, '0, '0, '0, 32'd60);       // wrap-around age
      send_request(ptsl_pkg::OP_TICK, '0, '0, '0, '0, 32'd200);
      send_request(ptsl_pkg::OP_REMOVE, 8'd13, '0, '0, '0, '0);
      send_request(ptsl_pkg::OP_REMOVE, 8'd200, '0, '0, '0, '0);
      send_request(ptsl_pkg::OP_UNUSED, 8'd10, 8'd1, 48'h100, 16'd1, 32'd1);
   endtask

   // Random churn across register settings, extremes included.
   task automatic test_random_churn();
      logic [31:0] limits [4];
      limits = '{32'd1, 32'd300, 32'd5000, 32'hFFFF_FFFF};
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(ptsl_pkg::CSR_SELF_ID,
                   (phase == 1) ? 48'h0 : (phase == 2) ? 48'hFF : 48'($urandom()));
         write_csr(ptsl_pkg::CSR_SELF_MAC,
                   (phase == 2) ? {ptsl_pkg::MAC_W{1'b1}} : mac_pool[phase]);
         write_csr(ptsl_pkg::CSR_TIMEOUT, 48'(limits[phase]));
         if (phase == 3) clock_ms = 32'hFFFF_F000;   // run time across the wrap
         for (int n = 0; n < 115; n++) begin
            send_random($urandom_range(0, 14) == 0);
            if (phase == 1 && n == 60) hold_until_drained();
         end
      end
   endtask

   // Last stretch: back-to-back requests with no gaps at all.
   task automatic test_back_to_back();
      allow_gaps = 1'b0;
      for (int n = 0; n < 60; n++) send_random(1'b0);
      start <= 1'b0;
   endtask

   initial begin
      fill_pools();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_churn();
      test_back_to_back();
      // wait out the tail, then allow for a late stray response
      while (pending_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Covered %0d requests of every kind over four register settings;",
               n_items);
      $display("%0d responses checked, %0d mismatches.", n_checked, n_errors);
      if (n_errors == 0 && pending_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
